@@ rtl/hvn_pkg.sv @@
// shared types and constants for the hashed 2d value noise pipeline
package hvn_pkg;

  // fixed point format of the sample coordinates
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned ValueW        = 24;

  // lattice and mixer hash multipliers
  localparam logic [CoordW-1:0] HashX = 32'h9E3779B1;
  localparam logic [CoordW-1:0] HashY = 32'h85EBCA77;
  localparam logic [CoordW-1:0] Mix1  = 32'h7FEB352D;
  localparam logic [CoordW-1:0] Mix2  = 32'h846CA68B;

  // fade product t2*p is Q0.2F with two guard bits, then aligned to Q0.24
  localparam int unsigned FadeProdW = 2 * FRACTION_BITS + 2;
  localparam int unsigned FadeShr   = (2 * FRACTION_BITS >= ValueW) ?
                                      (2 * FRACTION_BITS - ValueW) : 0;
  localparam int unsigned FadeShl   = (2 * FRACTION_BITS < ValueW) ?
                                      (ValueW - 2 * FRACTION_BITS) : 0;

  // blend products a*(1-s) and b*s stay below 2^(2*ValueW)
  localparam int unsigned BlendW = 2 * ValueW;

  // register stages from input transfer to output register
  localparam int unsigned NumStages = 8;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [ValueW-1:0]        value_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;

endpackage

@@ rtl/hvn_if.sv @@
// valid/ready channel interfaces for sample input and noise output
interface hvn_in_if;
  import hvn_pkg::*;

  logic   valid;
  logic   ready;
  coord_t sample_x;
  coord_t sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface hvn_out_if;
  import hvn_pkg::*;

  logic   valid;
  logic   ready;
  value_t noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

@@ rtl/hashed_value_noise_2d.sv @@
// top level: eight stage pipeline computing hashed 2d value noise with smoothstep fade
//
//  channel    dir  payload                      transfer
//  sample_i   in   sample_x, sample_y (Q16.16)  valid && ready
//  noise_o    out  noise_value (Q0.24)          valid && ready
//
// one sample per cycle sustained while noise_o is not stalled; an accepted sample passes
// through stage registers s1 to s8, and noise_o.valid rises once it reaches s8.
// the stage count is set by the hash chain (three dependent 32x32 multiplies) and the
// two blend levels (multiply stage, then add stage each).
// rst_ni clears only the stage valid bits; data registers are not reset.
// the whole pipeline advances together; it holds when the output register is full
// and not taken, so sample_i.ready follows noise_o.ready combinationally.
module hashed_value_noise_2d (
  input  logic      clk_i,
  input  logic      rst_ni,
  hvn_in_if.sink    sample_i,
  hvn_out_if.source noise_o
);
  import hvn_pkg::*;

  localparam logic [FRACTION_BITS+1:0] FadeThree = (FRACTION_BITS + 2)'(3) << FRACTION_BITS;
  localparam logic [ValueW:0]          OneQ24    = (ValueW + 1)'(1) << ValueW;

  logic                 en;
  logic [NumStages-1:0] valid_q;

  // stage registers
  logic [CoordW-1:0]          s1_hx0_q, s1_hx1_q, s1_hy0_q, s1_hy1_q;
  logic [2*FRACTION_BITS-1:0] s1_sqx_q, s1_sqy_q;
  frac_t                      s1_fx_q, s1_fy_q;
  logic [CoordW-1:0]          s2_v_q [4];
  logic [FadeProdW-1:0]       s2_prodx_q, s2_prody_q;
  logic [CoordW-1:0]          s3_v_q [4];
  value_t                     s3_sx_q, s3_sy_q;
  value_t                     s4_c_q [4];
  value_t                     s4_sx_q, s4_sy_q;
  logic [BlendW-1:0]          s5_p_q [4];
  value_t                     s5_sy_q;
  value_t                     s6_row0_q, s6_row1_q, s6_sy_q;
  logic [BlendW-1:0]          s7_q0_q, s7_q1_q;
  value_t                     s8_noise_q;

  // next values
  logic [CoordW-1:0]          s1_hx0_d, s1_hx1_d, s1_hy0_d, s1_hy1_d;
  logic [2*FRACTION_BITS-1:0] s1_sqx_d, s1_sqy_d;
  frac_t                      s1_fx_d, s1_fy_d;
  logic [CoordW-1:0]          s2_v_d [4];
  logic [FadeProdW-1:0]       s2_prodx_d, s2_prody_d;
  logic [CoordW-1:0]          s3_v_d [4];
  value_t                     s3_sx_d, s3_sy_d;
  value_t                     s4_c_d [4];
  logic [BlendW-1:0]          s5_p_d [4];
  value_t                     s6_row0_d, s6_row1_d;
  logic [BlendW-1:0]          s7_q0_d, s7_q1_d;
  value_t                     s8_noise_d;

  // global advance: move unless the output register holds an untaken result
  assign en             = !valid_q[NumStages-1] || noise_o.ready;
  assign sample_i.ready = en;
  assign noise_o.valid  = valid_q[NumStages-1];
  assign noise_o.noise_value = s8_noise_q;

  // stage 1: floor split, neighbor corners, lattice multiplies, fraction squares
  always_comb begin
    logic [CoordW-1:0] ix, iy, ix1, iy1;
    ix  = CoordW'(sample_i.sample_x >>> FRACTION_BITS);
    iy  = CoordW'(sample_i.sample_y >>> FRACTION_BITS);
    ix1 = ix + CoordW'(1);
    iy1 = iy + CoordW'(1);
    s1_fx_d  = sample_i.sample_x[FRACTION_BITS-1:0];
    s1_fy_d  = sample_i.sample_y[FRACTION_BITS-1:0];
    s1_hx0_d = ix  * HashX;
    s1_hx1_d = ix1 * HashX;
    s1_hy0_d = iy  * HashY;
    s1_hy1_d = iy1 * HashY;
    s1_sqx_d = (2 * FRACTION_BITS)'(s1_fx_d) * (2 * FRACTION_BITS)'(s1_fx_d);
    s1_sqy_d = (2 * FRACTION_BITS)'(s1_fy_d) * (2 * FRACTION_BITS)'(s1_fy_d);
  end

  // stage 2: corner seeds, first mixer round, fade product t2*(3-2t)
  always_comb begin
    logic [CoordW-1:0]        seed [4];
    logic [CoordW-1:0]        w;
    logic [FRACTION_BITS+1:0] px, py;
    seed[0] = s1_hx0_q ^ s1_hy0_q;
    seed[1] = s1_hx1_q ^ s1_hy0_q;
    seed[2] = s1_hx0_q ^ s1_hy1_q;
    seed[3] = s1_hx1_q ^ s1_hy1_q;
    for (int c = 0; c < 4; c++) begin
      w         = seed[c] ^ (seed[c] >> 16);
      s2_v_d[c] = w * Mix1;
    end
    px = FadeThree - (FRACTION_BITS + 2)'({s1_fx_q, 1'b0});
    py = FadeThree - (FRACTION_BITS + 2)'({s1_fy_q, 1'b0});
    s2_prodx_d = FadeProdW'(s1_sqx_q[2*FRACTION_BITS-1:FRACTION_BITS]) * FadeProdW'(px);
    s2_prody_d = FadeProdW'(s1_sqy_q[2*FRACTION_BITS-1:FRACTION_BITS]) * FadeProdW'(py);
  end

  // stage 3: second mixer round, fade aligned to Q0.24
  always_comb begin
    logic [CoordW-1:0]            w;
    logic [FadeProdW+FadeShl-1:0] ax, ay;
    for (int c = 0; c < 4; c++) begin
      w         = s2_v_q[c] ^ (s2_v_q[c] >> 15);
      s3_v_d[c] = w * Mix2;
    end
    ax = (FadeProdW + FadeShl)'(s2_prodx_q) << FadeShl;
    ay = (FadeProdW + FadeShl)'(s2_prody_q) << FadeShl;
    s3_sx_d = ValueW'(ax >> FadeShr);
    s3_sy_d = ValueW'(ay >> FadeShr);
  end

  // stage 4: final xorshift, keep low 24 bits as corner value
  always_comb begin
    logic [CoordW-1:0] w;
    for (int c = 0; c < 4; c++) begin
      w         = s3_v_q[c] ^ (s3_v_q[c] >> 16);
      s4_c_d[c] = w[ValueW-1:0];
    end
  end

  // stage 5: x blend products
  always_comb begin
    logic [ValueW:0] wsx;
    wsx = OneQ24 - (ValueW + 1)'(s4_sx_q);
    s5_p_d[0] = BlendW'((BlendW + 1)'(s4_c_q[0]) * (BlendW + 1)'(wsx));
    s5_p_d[1] = BlendW'((BlendW + 1)'(s4_c_q[1]) * (BlendW + 1)'(s4_sx_q));
    s5_p_d[2] = BlendW'((BlendW + 1)'(s4_c_q[2]) * (BlendW + 1)'(wsx));
    s5_p_d[3] = BlendW'((BlendW + 1)'(s4_c_q[3]) * (BlendW + 1)'(s4_sx_q));
  end

  // stage 6: x blend sums, truncated to Q0.24
  always_comb begin
    logic [BlendW:0] r0, r1;
    r0 = (BlendW + 1)'(s5_p_q[0]) + (BlendW + 1)'(s5_p_q[1]);
    r1 = (BlendW + 1)'(s5_p_q[2]) + (BlendW + 1)'(s5_p_q[3]);
    s6_row0_d = r0[BlendW-1:ValueW];
    s6_row1_d = r1[BlendW-1:ValueW];
  end

  // stage 7: y blend products
  always_comb begin
    logic [ValueW:0] wsy;
    wsy     = OneQ24 - (ValueW + 1)'(s6_sy_q);
    s7_q0_d = BlendW'((BlendW + 1)'(s6_row0_q) * (BlendW + 1)'(wsy));
    s7_q1_d = BlendW'((BlendW + 1)'(s6_row1_q) * (BlendW + 1)'(s6_sy_q));
  end

  // stage 8: y blend sum into the output register
  always_comb begin
    logic [BlendW:0] r;
    r          = (BlendW + 1)'(s7_q0_q) + (BlendW + 1)'(s7_q1_q);
    s8_noise_d = r[BlendW-1:ValueW];
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], sample_i.valid};
    end
  end

  // data registers, held while stalled
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_hx0_q   <= s1_hx0_d;
      s1_hx1_q   <= s1_hx1_d;
      s1_hy0_q   <= s1_hy0_d;
      s1_hy1_q   <= s1_hy1_d;
      s1_sqx_q   <= s1_sqx_d;
      s1_sqy_q   <= s1_sqy_d;
      s1_fx_q    <= s1_fx_d;
      s1_fy_q    <= s1_fy_d;
      s2_v_q     <= s2_v_d;
      s2_prodx_q <= s2_prodx_d;
      s2_prody_q <= s2_prody_d;
      s3_v_q     <= s3_v_d;
      s3_sx_q    <= s3_sx_d;
      s3_sy_q    <= s3_sy_d;
      s4_c_q     <= s4_c_d;
      s4_sx_q    <= s3_sx_q;
      s4_sy_q    <= s3_sy_q;
      s5_p_q     <= s5_p_d;
      s5_sy_q    <= s4_sy_q;
      s6_row0_q  <= s6_row0_d;
      s6_row1_q  <= s6_row1_d;
      s6_sy_q    <= s5_sy_q;
      s7_q0_q    <= s7_q0_d;
      s7_q1_q    <= s7_q1_d;
      s8_noise_q <= s8_noise_d;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted sample occupies the first stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> valid_q[0])
    else $error("accepted sample did not enter stage 1");

  // on advance every occupied stage moves one step down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (valid_q[NumStages-1:1] == $past(valid_q[NumStages-2:0])))
    else $error("pipeline valid bits did not shift on advance");

  // a stall keeps the valid bits and the output register as they were
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(valid_q) && $stable(s8_noise_q)))
    else $error("pipeline changed during stall");

  // a stalled result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (noise_o.valid && !noise_o.ready) |-> !sample_i.ready)
    else $error("input accepted while output stalled");
`endif

endmodule
